// ===== rtl/tara_pkg.sv =====
// ----------------------------------------------------------------------------
// tara_pkg
// Shared types and constants of the texture atlas rectangle allocator.
// ----------------------------------------------------------------------------
package tara_pkg;

   localparam int SLACK_W = 16;
   localparam int SCORE_W = 32;

   localparam logic [SLACK_W-1:0] SLACK_INIT = 16'hffff;
   localparam logic [SCORE_W-1:0] SCORE_INIT = 32'h00ffffff;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_SIZE   = 2'd1,
      ST_CACHE_FULL = 2'd2,
      ST_STORE_FULL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_PAGE_WIDTH  = 2'd0,
      REG_PAGE_HEIGHT = 2'd1,
      REG_MAX_PAGES   = 2'd2,
      REG_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_SCAN,
      FS_SCORE,
      FS_DECIDE,
      FS_SHIFT,
      FS_APPEND,
      FS_RESP
   } fsm_type;

   typedef enum logic [1:0] {
      PC_UPPER_RIGHT = 2'd0,
      PC_LOWER_LEFT  = 2'd1,
      PC_LOWER_RIGHT = 2'd2,
      PC_NONE        = 2'd3
   } piece_type;

endpackage

// ===== rtl/tara_mem.sv =====
// ----------------------------------------------------------------------------
// tara_mem
// Free rectangle store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tara_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 53,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tara_lanes.sv =====
// ----------------------------------------------------------------------------
// tara_lanes
// Per-page best-fit trackers, updated as entries stream newest to oldest.
// ----------------------------------------------------------------------------
module tara_lanes #(
   parameter int PAGES = 8,
   parameter int PB    = 3,
   parameter int RB    = 8,
   parameter int CB    = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clr,
   input  logic                          upd,
   input  logic [PB-1:0]                 e_page,
   input  logic [tara_pkg::SLACK_W-1:0]  e_w,
   input  logic [tara_pkg::SLACK_W-1:0]  e_h,
   input  logic [CB-1:0]                 e_x,
   input  logic [CB-1:0]                 e_y,
   input  logic [RB-1:0]                 e_rank,
   input  logic [tara_pkg::SLACK_W-1:0]  q_w,
   input  logic [tara_pkg::SLACK_W-1:0]  q_h,
   input  logic [PB-1:0]                 sel,
   output logic                          o_found,
   output logic [tara_pkg::SLACK_W-1:0]  o_dw,
   output logic [tara_pkg::SLACK_W-1:0]  o_dh,
   output logic [RB-1:0]                 o_rank,
   output logic [CB-1:0]                 o_x,
   output logic [CB-1:0]                 o_y
);
   import tara_pkg::*;

   logic [PAGES-1:0]   found_ff, found_in;
   logic [SLACK_W-1:0] dw_ff [PAGES];
   logic [SLACK_W-1:0] dh_ff [PAGES];
   logic [RB-1:0]      rank_ff [PAGES];
   logic [CB-1:0]      x_ff [PAGES];
   logic [CB-1:0]      y_ff [PAGES];
   logic [PAGES-1:0]   hit;
   logic               fits;
   logic [SLACK_W-1:0] dw, dh;

   assign fits = (e_w >= q_w) && (e_h >= q_h);
   assign dw   = e_w - q_w;
   assign dh   = e_h - q_h;

   always_comb begin
      for (int i = 0; i < PAGES; i++) begin
         hit[i] = upd && fits && (e_page == PB'(i)) &&
                  (!found_ff[i] || ((dw <= dw_ff[i]) && (dh <= dh_ff[i])));
         found_in[i] = clr ? 1'b0 : (found_ff[i] | hit[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
      end else begin
         found_ff <= found_in;
      end
   end

   // slack regs only count once the lane has a fit; before that any fit wins
   always_ff @(posedge clock) begin
      for (int i = 0; i < PAGES; i++) begin
         if (hit[i]) begin
            dw_ff[i]   <= dw;
            dh_ff[i]   <= dh;
            rank_ff[i] <= e_rank;
            x_ff[i]    <= e_x;
            y_ff[i]    <= e_y;
         end
      end
   end

   assign o_found = found_ff[sel];
   assign o_dw    = dw_ff[sel];
   assign o_dh    = dh_ff[sel];
   assign o_rank  = rank_ff[sel];
   assign o_x     = x_ff[sel];
   assign o_y     = y_ff[sel];

endmodule

// ===== rtl/texture_atlas_rect_allocator.sv =====
// ----------------------------------------------------------------------------
// texture_atlas_rect_allocator
// Guillotine best-fit rectangle allocator over a set of atlas pages.
// ----------------------------------------------------------------------------
// Each word scans all n free rectangles, scores the PAGES lanes, then
//   compacts the entries above the chosen rank r, all through the
//   single read port of the rank-ordered store (scan, then compaction).
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: store empty, no page open, registers back to 256 x 256, 8 pages.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module texture_atlas_rect_allocator #(
   parameter int FREE_RECTS = 256,
   parameter int PAGES      = 8,
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [12:0] req_width,
   input  logic [12:0] req_height,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_page_index,
   output logic [11:0] rsp_x_offset,
   output logic [11:0] rsp_y_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import tara_pkg::*;

   localparam int RB = (FREE_RECTS > 1) ? $clog2(FREE_RECTS) : 1;
   localparam int NB = RB + 1;
   localparam int PB = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CB = COORD_BITS;
   localparam int DB = COORD_BITS + 1;
   localparam int EW = 2 * DB + 2 * CB + PB;
   localparam logic [SLACK_W-1:0] MAX_DIM  = SLACK_W'(1 << COORD_BITS);
   localparam logic [NB:0]        FR_LIM   = (NB+1)'(FREE_RECTS);
   localparam logic [7:0]         PAGES8   = 8'(PAGES);
   localparam logic [NB-1:0]      PAGES_N  = NB'(PAGES);

   // ---------------- configuration registers ----------------
   logic [12:0] pw_ff, ph_ff;
   logic [3:0]  mp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff <= 13'd256;
         ph_ff <= 13'd256;
         mp_ff <= 4'd8;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_PAGE_WIDTH:  pw_ff <= csr_data;
            REG_PAGE_HEIGHT: ph_ff <= csr_data;
            REG_MAX_PAGES:   mp_ff <= csr_data[3:0];
            REG_UNUSED:      ;
         endcase
      end
   end

   // page size clamped to the coordinate range
   logic [SLACK_W-1:0] pw16, ph16;
   logic [7:0]         mp8, lim8, opc8;

   assign pw16 = ({3'b0, pw_ff} > MAX_DIM) ? MAX_DIM : {3'b0, pw_ff};
   assign ph16 = ({3'b0, ph_ff} > MAX_DIM) ? MAX_DIM : {3'b0, ph_ff};
   assign mp8  = {4'b0, mp_ff};
   assign lim8 = (mp8 < PAGES8) ? mp8 : PAGES8;

   // ---------------- state ----------------
   fsm_type            state_ff, state_in;
   logic [NB-1:0]      n_ff, n_in;          // free rectangles held, by rank
   logic [PB:0]        opc_ff, opc_in;      // open pages
   logic [NB-1:0]      cnt_ff, cnt_in;      // scan countdown / shift pointer
   logic [PB:0]        sc_ff, sc_in;        // score countdown
   logic               rd_vld_ff, rd_vld_in;
   logic [RB-1:0]      rd_addr_ff, rd_addr_in;
   logic [SLACK_W-1:0] rw_ff, rw_in, rh_ff, rh_in;

   logic               s1_vld_ff, s1_vld_in;
   logic [SCORE_W-1:0] s1_prod_ff, s1_prod_in;
   logic [SLACK_W-1:0] s1_dw_ff, s1_dh_ff;
   logic [RB-1:0]      s1_rank_ff;
   logic [CB-1:0]      s1_x_ff, s1_y_ff;
   logic [PB-1:0]      s1_page_ff;

   logic               bst_vld_ff, bst_vld_in;
   logic [SCORE_W-1:0] bst_score_ff, bst_score_in;
   logic [SLACK_W-1:0] bst_dw_ff, bst_dh_ff;
   logic [RB-1:0]      bst_rank_ff;
   logic [CB-1:0]      bst_x_ff, bst_y_ff;
   logic [PB-1:0]      bst_page_ff;
   logic               bst_take;

   logic [PB-1:0]      pg_ff, pg_in;
   logic [CB-1:0]      x_ff, x_in, y_ff, y_in;
   logic [SLACK_W-1:0] gw_ff, gw_in, gh_ff, gh_in;
   piece_type          kind_ff, kind_in;

   status_type         status_ff, status_in;
   logic [PB-1:0]      rpage_ff, rpage_in;
   logic [CB-1:0]      rx_ff, rx_in, ry_ff, ry_in;

   // ---------------- store and lanes ----------------
   logic           mem_we;
   logic [RB-1:0]  mem_waddr, mem_raddr;
   logic [EW-1:0]  mem_wdata, mem_rdata;

   tara_mem #(.DEPTH(FREE_RECTS), .WIDTH(EW), .AW(RB)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // entry word: {page, y, x, h, w}
   logic [DB-1:0] e_w, e_h;
   logic [CB-1:0] e_x, e_y;
   logic [PB-1:0] e_page;

   assign {e_page, e_y, e_x, e_h, e_w} = mem_rdata;

   logic               lane_clr, lane_upd;
   logic [PB-1:0]      lane_sel;
   logic               ln_found;
   logic [SLACK_W-1:0] ln_dw, ln_dh;
   logic [RB-1:0]      ln_rank;
   logic [CB-1:0]      ln_x, ln_y;

   tara_lanes #(.PAGES(PAGES), .PB(PB), .RB(RB), .CB(CB)) u_lanes (
      .clock   (clock),
      .reset   (reset),
      .clr     (lane_clr),
      .upd     (lane_upd),
      .e_page  (e_page),
      .e_w     (SLACK_W'(e_w)),
      .e_h     (SLACK_W'(e_h)),
      .e_x     (e_x),
      .e_y     (e_y),
      .e_rank  (rd_addr_ff),
      .q_w     (rw_ff),
      .q_h     (rh_ff),
      .sel     (lane_sel),
      .o_found (ln_found),
      .o_dw    (ln_dw),
      .o_dh    (ln_dh),
      .o_rank  (ln_rank),
      .o_x     (ln_x),
      .o_y     (ln_y)
   );

   assign lane_upd = (state_ff == FS_SCAN) && rd_vld_ff;
   assign lane_sel = sc_ff[PB-1:0] - PB'(1);

   // score compare: strictly smaller wins, pages visited newest first
   assign bst_take = s1_vld_ff && (s1_prod_ff < bst_score_ff);

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s1_dw_ff   <= ln_dw;
      s1_dh_ff   <= ln_dh;
      s1_rank_ff <= ln_rank;
      s1_x_ff    <= ln_x;
      s1_y_ff    <= ln_y;
      s1_page_ff <= lane_sel;
      if (bst_take) begin
         bst_dw_ff   <= s1_dw_ff;
         bst_dh_ff   <= s1_dh_ff;
         bst_rank_ff <= s1_rank_ff;
         bst_x_ff    <= s1_x_ff;
         bst_y_ff    <= s1_y_ff;
         bst_page_ff <= s1_page_ff;
      end
      bst_score_ff <= bst_score_in;
      rw_ff   <= rw_in;
      rh_ff   <= rh_in;
      pg_ff   <= pg_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      gw_ff   <= gw_in;
      gh_ff   <= gh_in;
      rd_addr_ff <= rd_addr_in;
      status_ff <= status_in;
      rpage_ff  <= rpage_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FS_IDLE;
         n_ff         <= '0;
         opc_ff       <= '0;
         cnt_ff       <= '0;
         sc_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         bst_vld_ff   <= 1'b0;
         kind_ff      <= PC_UPPER_RIGHT;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         opc_ff       <= opc_in;
         cnt_ff       <= cnt_in;
         sc_ff        <= sc_in;
         rd_vld_ff    <= rd_vld_in;
         s1_vld_ff    <= s1_vld_in;
         bst_vld_ff   <= bst_vld_in;
         kind_ff      <= kind_in;
      end
   end

   // ---------------- sequencer ----------------
   logic [SLACK_W-1:0] d_gw, d_gh;
   logic [1:0]         pieces;
   logic [NB:0]        need, have;
   logic [CB-1:0]      rw_c, rh_c;

   assign rw_c = rw_ff[CB-1:0];
   assign rh_c = rh_ff[CB-1:0];
   assign opc8 = 8'(opc_ff);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      opc_in       = opc_ff;
      cnt_in       = cnt_ff;
      sc_in        = sc_ff;
      rd_vld_in    = 1'b0;
      rd_addr_in   = rd_addr_ff;
      rw_in        = rw_ff;
      rh_in        = rh_ff;
      s1_vld_in    = 1'b0;
      s1_prod_in   = {16'b0, ln_dw} * {16'b0, ln_dh};
      bst_vld_in   = bst_vld_ff | bst_take;
      bst_score_in = bst_take ? s1_prod_ff : bst_score_ff;
      pg_in        = pg_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      gw_in        = gw_ff;
      gh_in        = gh_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      rpage_in     = rpage_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      lane_clr     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = n_ff[RB-1:0];
      mem_wdata    = '0;
      mem_raddr    = cnt_ff[RB-1:0];
      d_gw         = '0;
      d_gh         = '0;
      pieces       = '0;
      need         = '0;
      have         = '0;

      unique case (state_ff)
         FS_IDLE: begin
            if (start) begin
               rw_in        = {3'b0, req_width};
               rh_in        = {3'b0, req_height};
               lane_clr     = 1'b1;
               bst_vld_in   = 1'b0;
               bst_score_in = SCORE_INIT;
               status_in    = ST_OK;
               rpage_in     = '0;
               rx_in        = '0;
               ry_in        = '0;
               if (req_width == '0 || req_height == '0 ||
                   {3'b0, req_width} > pw16 || {3'b0, req_height} > ph16) begin
                  status_in = ST_BAD_SIZE;
                  state_in  = FS_RESP;
               end else begin
                  cnt_in   = n_ff;
                  state_in = FS_SCAN;
               end
            end
         end

         // newest rank first; lanes update in the cycle after each read
         FS_SCAN: begin
            if (cnt_ff != '0) begin
               mem_raddr  = RB'(cnt_ff - NB'(1));
               rd_addr_in = mem_raddr;
               rd_vld_in  = 1'b1;
               cnt_in     = cnt_ff - NB'(1);
            end else if (!rd_vld_ff) begin
               sc_in    = (PB+1)'(PAGES_N);
               state_in = FS_SCORE;
            end
         end

         FS_SCORE: begin
            if (sc_ff != '0) begin
               s1_vld_in = ln_found;
               sc_in     = sc_ff - (PB+1)'(1);
            end else if (!s1_vld_ff) begin
               state_in = FS_DECIDE;
            end
         end

         FS_DECIDE: begin
            if (bst_vld_ff) begin
               pg_in    = bst_page_ff;
               x_in     = bst_x_ff;
               y_in     = bst_y_ff;
               d_gw     = bst_dw_ff;
               d_gh     = bst_dh_ff;
            end else begin
               pg_in    = opc_ff[PB-1:0];
               x_in     = '0;
               y_in     = '0;
               d_gw     = pw16 - rw_ff;
               d_gh     = ph16 - rh_ff;
            end
            gw_in  = d_gw;
            gh_in  = d_gh;
            pieces = 2'((d_gw != '0) ? 1 : 0) + 2'((d_gh != '0) ? 1 : 0) +
                     2'(((d_gw != '0) && (d_gh != '0)) ? 1 : 0);
            need   = (NB+1)'(pieces) + (NB+1)'(n_ff);
            have   = FR_LIM + (NB+1)'(bst_vld_ff ? 1 : 0);
            kind_in = PC_UPPER_RIGHT;
            if (!bst_vld_ff && opc8 >= lim8) begin
               status_in = ST_CACHE_FULL;
               state_in  = FS_RESP;
            end else if (need > have) begin
               status_in = ST_STORE_FULL;
               state_in  = FS_RESP;
            end else if (bst_vld_ff) begin
               cnt_in   = NB'(bst_rank_ff) + NB'(1);
               state_in = FS_SHIFT;
            end else begin
               opc_in   = opc_ff + (PB+1)'(1);
               state_in = FS_APPEND;
            end
         end

         // close the gap left by the chosen rank: move each newer entry down
         FS_SHIFT: begin
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff - RB'(1);
               mem_wdata = mem_rdata;
            end
            if (cnt_ff < n_ff) begin
               mem_raddr  = cnt_ff[RB-1:0];
               rd_addr_in = cnt_ff[RB-1:0];
               rd_vld_in  = 1'b1;
               cnt_in     = cnt_ff + NB'(1);
            end else if (!rd_vld_ff) begin
               n_in     = n_ff - NB'(1);
               state_in = FS_APPEND;
            end
         end

         // pieces go on top as the newest ranks
         FS_APPEND: begin
            unique case (kind_ff)
               PC_UPPER_RIGHT: begin
                  mem_we    = (gw_ff != '0);
                  mem_wdata = {pg_ff, y_ff, x_ff + rw_c, DB'(rh_ff), DB'(gw_ff)};
                  kind_in   = PC_LOWER_LEFT;
               end
               PC_LOWER_LEFT: begin
                  mem_we    = (gh_ff != '0);
                  mem_wdata = {pg_ff, y_ff + rh_c, x_ff, DB'(gh_ff), DB'(rw_ff)};
                  kind_in   = PC_LOWER_RIGHT;
               end
               PC_LOWER_RIGHT: begin
                  mem_we    = (gw_ff != '0) && (gh_ff != '0);
                  mem_wdata = {pg_ff, y_ff + rh_c, x_ff + rw_c, DB'(gh_ff), DB'(gw_ff)};
                  kind_in   = PC_NONE;
                  rpage_in  = pg_ff;
                  rx_in     = x_ff;
                  ry_in     = y_ff;
                  state_in  = FS_RESP;
               end
               PC_NONE: begin
                  state_in = FS_RESP;
               end
            endcase
            if (mem_we) begin
               n_in = n_ff + NB'(1);
            end
         end

         FS_RESP: begin
            state_in = FS_IDLE;
         end

         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   // ---------------- result ports ----------------
   // strobe is high for the single cycle spent in FS_RESP
   logic          resp_now;
   logic [7:0]    pg8;
   logic [15:0]   rx16, ry16;

   assign resp_now = (state_ff == FS_RESP);
   assign pg8  = 8'(rpage_ff);
   assign rx16 = 16'(rx_ff);
   assign ry16 = 16'(ry_ff);

   assign busy           = (state_ff != FS_IDLE);
   assign rsp_valid      = resp_now;
   assign rsp_status     = status_ff;
   assign rsp_page_index = pg8[2:0];
   assign rsp_x_offset   = rx16[11:0];
   assign rsp_y_offset   = ry16[11:0];

   // ---------------- checks ----------------
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("result strobe not followed by idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (n_ff <= NB'(FREE_RECTS)) && (opc_ff <= (PB+1)'(PAGES_N)))
      else $error("store or page count out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_x_offset == '0 && rsp_y_offset == '0 && rsp_page_index == '0)
      else $error("failed request carries a placement");

endmodule
